FILE: sv/alt_pkg.sv
// Package for the adaptive lateness timer: item structs, register indexes,
// configuration widths and reset values. No dependencies.
`default_nettype none

package alt_pkg;

    // Field widths
    localparam int TIME_W = 32;
    localparam int LATE_W = 16;
    localparam int MIN_W  = 10;
    localparam int MARK_W = 16;
    localparam int PER_W  = 10;
    localparam int LAG_W  = 4;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 3;

    typedef logic [CIDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx REG_MIN_INTERVAL = 3'd0;
    localparam t_cfg_idx REG_HIGH_MARK    = 3'd1;
    localparam t_cfg_idx REG_LOW_MARK     = 3'd2;
    localparam t_cfg_idx REG_CHECK_PERIOD = 3'd3;
    localparam t_cfg_idx REG_CHECK_LAG    = 3'd4;

    // Reset values
    localparam logic [MIN_W-1:0]  RST_MIN_INTERVAL = 10'd100;
    localparam logic [MARK_W-1:0] RST_HIGH_MARK    = 16'd200;
    localparam logic [MARK_W-1:0] RST_LOW_MARK     = 16'd50;
    localparam logic [PER_W-1:0]  RST_CHECK_PERIOD = 10'd100;
    localparam logic [LAG_W-1:0]  RST_CHECK_LAG    = 4'd3;

    typedef struct packed {
        logic [TIME_W-1:0] scheduled_ms;
        logic [TIME_W-1:0] actual_ms;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0] next_due_ms;
        logic [LATE_W-1:0] interval_ms;
        logic [LATE_W-1:0] mean_lateness;
        logic              adjusted;
    } t_out_item;

endpackage

`default_nettype wire

FILE: sv/adaptive_lateness_timer.sv
// Top level of the adaptive lateness timer: lateness window, mean, interval control.
// Depends on alt_pkg and alt_ram.
`default_nettype none

// Takes one tick item per clock cycle, sustained, while result items are taken.
// Each tick passes four register stages (lateness, window update, mean,
// interval control), and its result item is valid once the tick has passed
// all four. A stalled result holds the stages behind it, and the input stalls
// only once all four stages are full.
// The lateness window lives in a RAM with one write and one registered read
// port. The read runs one slot ahead of the write pointer, so every tick finds
// its outgoing entry already read. The window is zero after reset through one
// valid flag per entry; there is no clearing pass. The mean is the window sum
// times a fixed reciprocal, exact for any window depth.
// Configuration writes are taken on any cycle and must only happen while idle.
module adaptive_lateness_timer #(
    parameter int WINDOW_DEPTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Tick items
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire alt_pkg::t_in_item     i_in_item,
    // Result items
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output alt_pkg::t_out_item         o_out_item,
    // Configuration
    input  wire logic                  i_cfg_we,
    input  wire alt_pkg::t_cfg_idx     i_cfg_idx,
    input  wire logic [alt_pkg::CFG_W-1:0] i_cfg_wdata
);

    import alt_pkg::*;

    localparam int IDX_W   = $clog2(WINDOW_DEPTH);
    localparam int SUM_W   = IDX_W + LATE_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int SHIFT   = SUM_W + IDX_W;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / depth): exact quotient for every SUM_W-bit sum
    localparam logic [64:0] RECIP_FULL =
        ((65'd1 << SHIFT) + 65'(WINDOW_DEPTH) - 65'd1) / 65'(WINDOW_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

    // Configuration registers
    logic [MIN_W-1:0]  r_min_interval;
    logic [MARK_W-1:0] r_high_mark;
    logic [MARK_W-1:0] r_low_mark;
    logic [PER_W-1:0]  r_check_period;
    logic [LAG_W-1:0]  r_check_lag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= RST_MIN_INTERVAL;
            r_high_mark    <= RST_HIGH_MARK;
            r_low_mark     <= RST_LOW_MARK;
            r_check_period <= RST_CHECK_PERIOD;
            r_check_lag    <= RST_CHECK_LAG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_INTERVAL: r_min_interval <= i_cfg_wdata[MIN_W-1:0];
                REG_HIGH_MARK:    r_high_mark    <= i_cfg_wdata[MARK_W-1:0];
                REG_LOW_MARK:     r_low_mark     <= i_cfg_wdata[MARK_W-1:0];
                REG_CHECK_PERIOD: r_check_period <= i_cfg_wdata[PER_W-1:0];
                REG_CHECK_LAG:    r_check_lag    <= i_cfg_wdata[LAG_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;
    logic acc, upd2, upd4;

    assign adv4 = !r_v4 || i_out_ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign acc  = i_in_valid && adv1;
    assign upd2 = r_v1 && adv2;
    assign upd4 = r_v3 && adv4;

    assign o_in_ready  = adv1;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    // Stage 1: clamped lateness
    logic [TIME_W-1:0] diff;
    logic [LATE_W-1:0] late;
    logic [TIME_W-1:0] r1_actual, r2_actual, r3_actual;
    logic [LATE_W-1:0] r1_late;

    assign diff = i_in_item.actual_ms - i_in_item.scheduled_ms;

    always_comb begin
        if (diff[TIME_W-1]) begin
            late = '0;                  // early tick
        end else if (|diff[TIME_W-2:LATE_W]) begin
            late = '1;                  // saturate
        end else begin
            late = diff[LATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_actual <= i_in_item.actual_ms;
            r1_late   <= late;
        end
    end

    // Stage 2: window replace and running sum
    logic [IDX_W-1:0]        r_index;
    logic [IDX_W-1:0]        n_index;
    logic [IDX_W-1:0]        rd_addr;
    logic [WINDOW_DEPTH-1:0] r_wvalid;
    logic [LATE_W-1:0]       ram_rdata;
    logic [LATE_W-1:0]       old_late;
    logic [SUM_W-1:0]        r_sum;
    logic [SUM_W-1:0]        n_sum;
    logic [SUM_W-1:0]        r2_sum;

    assign n_index  = (r_index == LAST_IDX) ? '0 : r_index + 1'b1;
    // Read one slot ahead so the outgoing entry is ready when the next item comes
    assign rd_addr  = upd2 ? n_index : r_index;
    assign old_late = r_wvalid[r_index] ? ram_rdata : '0;
    assign n_sum    = r_sum - SUM_W'(old_late) + SUM_W'(r1_late);

    alt_ram #(
        .WIDTH (LATE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (upd2),
        .i_waddr (r_index),
        .i_wdata (r1_late),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index  <= '0;
            r_wvalid <= '0;
            r_sum    <= '0;
        end else if (upd2) begin
            r_index           <= n_index;
            r_wvalid[r_index] <= 1'b1;
            r_sum             <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd2) begin
            r2_actual <= r1_actual;
            r2_sum    <= n_sum;
        end
    end

    // Stage 3: mean by reciprocal multiply
    logic [PROD_W-1:0] prod;
    logic [LATE_W-1:0] r3_mean;

    assign prod = PROD_W'(r2_sum) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (r_v2 && adv3) begin
            r3_actual <= r2_actual;
            r3_mean   <= prod[SHIFT +: LATE_W];
        end
    end

    // Stage 4: check counters, interval and result
    logic [PER_W-1:0]  r_ticks;
    logic [LAG_W-1:0]  r_high_cnt, r_low_cnt;
    logic [LATE_W-1:0] r_interval;
    logic [PER_W-1:0]  ticks_inc, n_ticks;
    logic              chk;
    logic [LAG_W:0]    hi_inc, lo_inc;
    logic [LAG_W-1:0]  hi_step, lo_step, n_high_cnt, n_low_cnt;
    logic [LATE_W-1:0] ivl_up, ivl_dn, floor_v, n_interval;
    logic              fire_hi, fire_lo;
    t_out_item         r_out;

    assign ticks_inc = r_ticks + 1'b1;
    assign chk       = ticks_inc >= r_check_period;
    assign n_ticks   = chk ? '0 : ticks_inc;
    assign hi_inc    = {1'b0, r_high_cnt} + 1'b1;
    assign lo_inc    = {1'b0, r_low_cnt} + 1'b1;

    always_comb begin
        // High counter: saturating up/down, held at or below lag
        if (r3_mean > r_high_mark) begin
            hi_step = (hi_inc > {1'b0, r_check_lag}) ? r_check_lag : hi_inc[LAG_W-1:0];
        end else begin
            hi_step = (r_high_cnt != '0) ? r_high_cnt - 1'b1 : '0;
        end
        n_high_cnt = (hi_step > r_check_lag) ? r_check_lag : hi_step;
        fire_hi    = n_high_cnt >= r_check_lag;

        // Low counter
        if (r3_mean < r_low_mark) begin
            lo_step = (lo_inc > {1'b0, r_check_lag}) ? r_check_lag : lo_inc[LAG_W-1:0];
        end else begin
            lo_step = (r_low_cnt != '0) ? r_low_cnt - 1'b1 : '0;
        end
        n_low_cnt = (lo_step > r_check_lag) ? r_check_lag : lo_step;
        fire_lo   = n_low_cnt >= r_check_lag;

        // Widen by 2 (saturating), then narrow by 1 (stop at 0)
        ivl_up = r_interval;
        if (chk && fire_hi) begin
            ivl_up = (r_interval >= 16'hFFFE) ? 16'hFFFF : r_interval + 16'd2;
        end
        ivl_dn = ivl_up;
        if (chk && fire_lo) begin
            ivl_dn = (ivl_up != '0) ? ivl_up - 1'b1 : '0;
        end

        // Floor at max(min_interval, 1)
        floor_v    = (r_min_interval == '0) ? 16'd1 : LATE_W'(r_min_interval);
        n_interval = (ivl_dn < floor_v) ? floor_v : ivl_dn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks    <= '0;
            r_high_cnt <= '0;
            r_low_cnt  <= '0;
            r_interval <= '0;
        end else if (upd4) begin
            r_ticks    <= n_ticks;
            r_interval <= n_interval;
            if (chk) begin
                r_high_cnt <= n_high_cnt;
                r_low_cnt  <= n_low_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd4) begin
            r_out.next_due_ms   <= r3_actual + TIME_W'(n_interval);
            r_out.interval_ms   <= n_interval;
            r_out.mean_lateness <= r3_mean;
            r_out.adjusted      <= n_interval != r_interval;
        end
    end

    assign o_out_item = r_out;

`ifndef ASSERT_OFF
    // Write pointer steps by one slot, wrapping, on every window update
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd2 |=> (r_index == (($past(r_index) == LAST_IDX) ? '0 : $past(r_index) + 1'b1)))
        else $error("window index did not advance");

    // Adjusted flag matches the change of the held interval
    a_adjusted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd4 |=> (r_out.adjusted == (r_interval != $past(r_interval))))
        else $error("adjusted flag disagrees with interval change");

    // A delivered interval is never zero
    a_interval_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.interval_ms != '0))
        else $error("zero interval delivered");

    // An accepted item always occupies the first stage next cycle
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_v1)
        else $error("accepted item lost at stage one");
`endif

endmodule

`default_nettype wire

FILE: sv/alt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module alt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: tb/adaptive_lateness_timer_test.sv
// Self-checking testbench for the adaptive lateness timer: queue-fed tick driver,
// result monitor and an in-bench model of the window, counters and interval.
// Depends on alt_pkg and the adaptive_lateness_timer RTL.
`default_nettype none

module adaptive_lateness_timer_test;
    import alt_pkg::*;

    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned RAND_PHASES    = 12;
    localparam int unsigned PHASE_TICKS    = 128;

    // Indexes past the register list, written to check they are ignored
    localparam t_cfg_idx REG_SPARE_LO = 3'd5;
    localparam t_cfg_idx REG_SPARE_HI = 3'd7;

    // Lateness regimes for runs of random ticks
    typedef enum int {
        LATE_QUIET,
        LATE_HEAVY,
        LATE_MID,
        LATE_EARLY,
        LATE_EXTREME
    } t_regime;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      cfg_we = 1'b0;
    t_cfg_idx  cfg_idx = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    adaptive_lateness_timer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Pending ticks and predicted results
    t_in_item  tick_q[$];
    t_out_item due_q[$];

    // Model copy of the registers
    int unsigned cfg_min, cfg_high, cfg_low, cfg_period, cfg_lag;

    // Model copy of the state
    logic [LATE_W-1:0] late_win [32];
    int unsigned win_sum;
    logic [4:0]  win_ptr;
    int unsigned ticks_chk, hi_cnt, lo_cnt, cur_ivl;

    // Handshake bookkeeping
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    bit          burst_mode = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned quiet_cycles = 0;

    int unsigned ticks_seen = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned settings_used = 1;
    int unsigned holds_done = 0;

    function automatic int unsigned draw_gap();
        return burst_mode ? 0 : $urandom_range(8, 0);
    endfunction

    // Advance the model by one tick and return the result it predicts
    function automatic t_out_item predict_next_due(t_in_item tick);
        t_out_item   res;
        logic [31:0] diff;
        logic [15:0] late;
        int unsigned mean, old_ivl, floor_ms;
        old_ivl = cur_ivl;
        diff = tick.actual_ms - tick.scheduled_ms;
        if (diff[31]) begin
            late = '0;
        end else if (diff > 32'hFFFF) begin
            late = 16'hFFFF;
        end else begin
            late = diff[15:0];
        end

        win_sum = win_sum - late_win[win_ptr] + late;
        late_win[win_ptr] = late;
        win_ptr = win_ptr + 5'd1;
        mean = win_sum / 32;
        if (mean > 32'hFFFF) mean = 32'hFFFF;

        // Periodic check: both counters saturate at the lag
        ticks_chk = (ticks_chk + 1) & 32'h3FF;
        if (ticks_chk >= cfg_period) begin
            ticks_chk = 0;
            if (mean > cfg_high) begin
                hi_cnt = (hi_cnt + 1 > cfg_lag) ? cfg_lag : hi_cnt + 1;
            end else begin
                hi_cnt = (hi_cnt > 0) ? hi_cnt - 1 : 0;
            end
            if (hi_cnt > cfg_lag) hi_cnt = cfg_lag;
            if (hi_cnt >= cfg_lag) cur_ivl = (cur_ivl + 2 > 32'hFFFF) ? 32'hFFFF : cur_ivl + 2;

            if (mean < cfg_low) begin
                lo_cnt = (lo_cnt + 1 > cfg_lag) ? cfg_lag : lo_cnt + 1;
            end else begin
                lo_cnt = (lo_cnt > 0) ? lo_cnt - 1 : 0;
            end
            if (lo_cnt > cfg_lag) lo_cnt = cfg_lag;
            if (lo_cnt >= cfg_lag) cur_ivl = (cur_ivl > 0) ? cur_ivl - 1 : 0;
        end

        // Floor, never below 1, then cap
        floor_ms = (cfg_min == 0) ? 1 : cfg_min;
        if (cur_ivl < floor_ms) cur_ivl = floor_ms;
        if (cur_ivl > 32'hFFFF) cur_ivl = 32'hFFFF;

        res.next_due_ms   = tick.actual_ms + cur_ivl;
        res.interval_ms   = cur_ivl[15:0];
        res.mean_lateness = mean[15:0];
        res.adjusted      = (cur_ivl != old_ivl);
        return res;
    endfunction

    task automatic report_mismatch(t_out_item want, t_out_item got, bit orphan);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            if (orphan) begin
                $display("mismatch %0d: result with nothing expected: due=%h ivl=%0d mean=%0d adj=%0d",
                         mismatches, got.next_due_ms, got.interval_ms, got.mean_lateness,
                         got.adjusted);
            end else begin
                $display("mismatch %0d: expected due=%h ivl=%0d mean=%0d adj=%0d",
                         mismatches, want.next_due_ms, want.interval_ms, want.mean_lateness,
                         want.adjusted);
                $display("             actual   due=%h ivl=%0d mean=%0d adj=%0d",
                         got.next_due_ms, got.interval_ms, got.mean_lateness, got.adjusted);
            end
        end
    endtask

    // Sample both handshakes, check results, predict accepted ticks, watchdog
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
            quiet_cycles = 0;
        end else begin
            in_taken  <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if (out_valid && out_ready) begin
                results_seen++;
                if (due_q.size() == 0) begin
                    report_mismatch(out_item, out_item, 1'b1);
                end else begin
                    want = due_q.pop_front();
                    if (out_item.next_due_ms !== want.next_due_ms ||
                        out_item.interval_ms !== want.interval_ms ||
                        out_item.mean_lateness !== want.mean_lateness ||
                        out_item.adjusted !== want.adjusted) begin
                        report_mismatch(want, out_item, 1'b0);
                    end
                end
            end
            if (in_valid && in_ready) begin
                due_q.push_back(predict_next_due(in_item));
                ticks_seen++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Tick driver: hold until accepted, then wait a drawn gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (in_valid) send_wait = draw_gap();
            if (send_wait > 0) begin
                send_wait--;
                in_valid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                in_item  <= tick_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: per-item stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_taken) recv_wait = draw_gap();
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_tick(logic [31:0] sched, logic [31:0] actual);
        t_in_item t;
        t.scheduled_ms = sched;
        t.actual_ms    = actual;
        tick_q.push_back(t);
    endtask

    // Wait until every tick went in and every result came out, then settle
    task automatic wait_idle();
        while (tick_q.size() != 0 || in_valid || due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_INTERVAL: cfg_min    = data & 16'h03FF;
            REG_HIGH_MARK:    cfg_high   = data;
            REG_LOW_MARK:     cfg_low    = data;
            REG_CHECK_PERIOD: cfg_period = data & 16'h03FF;
            REG_CHECK_LAG:    cfg_lag    = data & 16'h000F;
            default: ;
        endcase
    endtask

    // Write all five registers; unused upper bits carry junk
    task automatic set_config(int unsigned min_ms, int unsigned high, int unsigned low,
                              int unsigned period, int unsigned lag);
        write_reg(REG_MIN_INTERVAL, (16'($urandom) & 16'hFC00) | 16'(min_ms));
        write_reg(REG_HIGH_MARK, 16'(high));
        write_reg(REG_LOW_MARK, 16'(low));
        write_reg(REG_CHECK_PERIOD, (16'($urandom) & 16'hFC00) | 16'(period));
        write_reg(REG_CHECK_LAG, (16'($urandom) & 16'hFFF0) | 16'(lag));
        settings_used++;
    endtask

    function automatic logic [31:0] draw_lateness(t_regime regime);
        int unsigned lo, hi;
        lo = (cfg_low < cfg_high) ? cfg_low : cfg_high;
        hi = (cfg_low < cfg_high) ? cfg_high : cfg_low;
        case (regime)
            LATE_QUIET:   return $urandom_range(cfg_low, 0);
            LATE_HEAVY:   return $urandom_range(cfg_high + 2000, cfg_high + 1);
            LATE_MID:     return $urandom_range(hi, lo);
            LATE_EARLY:   return $urandom_range(32'hFFFFFFFF, 32'h80000000);
            default:      return $urandom_range(32'h7FFFFFFF, 32'h10000);
        endcase
    endfunction

    // Runs of ticks sharing a lateness regime, with some fully random noise
    task automatic fill_phase(int unsigned count);
        int unsigned left, run, pick, k;
        logic [31:0] sched;
        t_regime     regime;
        left = count;
        while (left > 0) begin
            run = $urandom_range(48, 16);
            if (run > left) run = left;
            pick = $urandom_range(9, 0);
            if (pick < 3) regime = LATE_QUIET;
            else if (pick < 6) regime = LATE_HEAVY;
            else if (pick < 8) regime = LATE_MID;
            else if (pick == 8) regime = LATE_EARLY;
            else regime = LATE_EXTREME;
            for (k = 0; k < run; k++) begin
                sched = $urandom;
                if ($urandom_range(9, 0) == 0) begin
                    push_tick(sched, $urandom);
                end else begin
                    push_tick(sched, sched + draw_lateness(regime));
                end
            end
            left -= run;
        end
    endtask

    initial begin : stimulus
        int unsigned p, k, hi;
        logic [31:0] sched;
        cfg_min    = RST_MIN_INTERVAL;
        cfg_high   = RST_HIGH_MARK;
        cfg_low    = RST_LOW_MARK;
        cfg_period = RST_CHECK_PERIOD;
        cfg_lag    = RST_CHECK_LAG;
        for (k = 0; k < 32; k++) late_win[k] = '0;
        win_sum   = 0;
        win_ptr   = '0;
        ticks_chk = 0;
        hi_cnt    = 0;
        lo_cnt    = 0;
        cur_ivl   = 0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: first-tick floor, early, very late and wrapping ticks
        push_tick(32'h0, 32'h0);
        push_tick(32'hFFFFFFFF, 32'hFFFFFFFF);
        push_tick(32'h1, 32'h0);
        push_tick(32'h0, 32'h80000000);
        push_tick(32'h0, 32'h7FFFFFFF);
        push_tick(32'h0, 32'h0000FFFF);
        push_tick(32'h0, 32'h00010000);
        push_tick(32'hFFFFFFF0, 32'h5);
        push_tick(32'hFFFF0000, 32'hFFFFFFFF);
        push_tick(32'h12345678, 32'h12355676);
        wait_idle();

        // Zero floor, zero period and zero lag: both adjustments on every tick
        set_config(0, 16'hFFFF, 0, 0, 0);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0001);
        burst_mode = 1'b1;
        push_tick(32'h0, 32'h0);
        push_tick(32'h100, 32'hFF);
        push_tick(32'hAAAA5555, 32'hAAABFFFF);
        push_tick(32'h0, 32'hFFFFFFFF);
        push_tick(32'hFFFFFFFF, 32'h0);
        push_tick(32'h5555AAAA, 32'h5555AAAA);
        push_tick(32'h7, 32'h2000);
        wait_idle();

        // Floor of 1000, largest lag, marks at opposite extremes
        set_config(1000, 0, 16'hFFFF, 1, 15);
        burst_mode = 1'b0;
        for (k = 0; k < 7; k++) begin
            sched = $urandom;
            push_tick(sched, sched + $urandom_range(3000, 1));
        end
        wait_idle();

        // Random phases, each under its own register setting
        for (p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: set_config(1, 200, 50, 1, 1);
                1: set_config(1000, 16'hFFFF, 0, 1023, 15);
                2: set_config(1, 100, 20, 2, 15);
                default: begin
                    hi = $urandom_range(3000, 0);
                    set_config(($urandom_range(3, 0) == 0) ? $urandom_range(20, 1)
                                                           : $urandom_range(1000, 1),
                               hi, $urandom_range(hi, 0), $urandom_range(8, 1),
                               $urandom_range(5, 1));
                end
            endcase
            burst_mode = ($urandom_range(3, 0) == 0);
            if (p == 3 || p == 8) begin
                // Stall the receiver while the sender keeps offering ticks
                burst_mode = 1'b1;
                fill_phase(PHASE_TICKS);
                hold_req = ~hold_req;
            end else begin
                fill_phase(PHASE_TICKS);
            end
            wait_idle();
        end

        $display("covered %0d ticks and %0d results over %0d register settings",
                 ticks_seen, results_seen, settings_used);
        $display("long receiver hold-offs: %0d, mismatches: %0d", holds_done, mismatches);
        if (mismatches == 0 && due_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
sv/alt_pkg.sv
sv/alt_ram.sv
sv/adaptive_lateness_timer.sv
tb/adaptive_lateness_timer_test.sv
